// ===== rtl/tfsl_pkg.sv =====
package tfsl_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFS_W   = 48;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned VIDX_W   = 3;
  localparam int unsigned SHIFT_W  = 7;

  localparam logic [COUNT_W-1:0] WINDOW_LEN   = 6'd40;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 6'd63;
  localparam logic [VIDX_W-1:0]  VARINT_COUNT = 3'd4;
  localparam logic [VIDX_W-1:0]  VIDX_OFFSET  = 3'd2;
  localparam logic [VIDX_W-1:0]  VIDX_SIZE    = 3'd3;
  localparam logic [SHIFT_W-1:0] DIGIT_BITS   = 7'd7;
  localparam logic [SHIFT_W-1:0] SHIFT_LIMIT  = 7'd64;

  localparam logic [WORD_W-1:0]  WINDOW_LEN_W = 64'd40;
  localparam logic [WORD_W-1:0]  SIG_LEN_W    = 64'd8;
  localparam logic [WORD_W-1:0]  OFFSET_LIMIT = 64'h0000_0100_0000_0000;
  localparam logic [OFFS_W-1:0]  MAX_SIZE_RST = 48'd2147483648;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_OFFSET = 3'd1,
    ST_WINDOW = 3'd2,
    ST_VARINT = 3'd3,
    ST_HANDLE = 3'd4,
    ST_START  = 3'd5,
    ST_SIZE   = 3'd6
  } status_t;

endpackage

// ===== rtl/tfsl_if.sv =====
// footer byte channel
interface tfsl_in_if import tfsl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              window_last;
  logic [OFFS_W-1:0] sig_offset;

  modport source (output valid, output data_byte, output window_last,
                  output sig_offset, input ready);
  modport sink (input valid, input data_byte, input window_last,
                input sig_offset, output ready);
endinterface

// result channel
interface tfsl_out_if import tfsl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [OFFS_W-1:0] backscan;
  logic [OFFS_W-1:0] file_size;

  modport source (output valid, output status, output backscan,
                  output file_size, input ready);
  modport sink (input valid, input status, input backscan,
                input file_size, output ready);
endinterface

// ===== rtl/table_footer_start_locator.sv =====
// Table footer start locator.
// footer: one footer byte per word, in window order; window_last marks the
//   40th byte and sig_offset (signature byte offset) is sampled with it.
// result: one word per window, issued for each word with window_last set:
//   status, backscan (signature minus file start) and file_size; both
//   distances read zero unless status is ok.
// cfg_wr_en / cfg_wr_data: writes max_size, the largest accepted file size.
//   Write only while no window is in flight.
// Throughput: one footer byte per clock while footer.ready is high. Each
//   byte is decoded when accepted (varint shift/or into a 64-bit accumulator).
// Pipeline: the last byte of a window is captured in the window record
//   register; the checks then run through four more registered stages
//   (sum, start, distances, size compare), each one wide add or compare.
// Stall: every stage holds while the one after it is full and holding,
//   so bytes keep flowing while a result waits; footer.ready drops only
//   when the whole check pipeline is full behind a stalled result.
// Reset: decode state clears, all stages empty, max_size = 2^31.
module table_footer_start_locator import tfsl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  tfsl_in_if.sink           footer,
  tfsl_out_if.source        result,
  input  logic              cfg_wr_en,
  input  logic [OFFS_W-1:0] cfg_wr_data
);

  // configuration
  logic [OFFS_W-1:0] max_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= MAX_SIZE_RST;
    end else if (cfg_wr_en) begin
      max_size <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------
  // Varint decode state
  // ---------------------------------------------------------------
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [VIDX_W-1:0]  varint_index, varint_index_next;
  logic [SHIFT_W-1:0] bit_shift, bit_shift_next;
  logic [WORD_W-1:0]  accumulator, accumulator_next;
  logic [WORD_W-1:0]  index_offset, index_offset_next;
  logic [WORD_W-1:0]  index_size, index_size_next;
  logic               varint_error, varint_error_next;

  logic               in_accept;
  logic               last_accept;
  logic               decode_en;
  logic [WORD_W-1:0]  acc_or;
  logic [SHIFT_W-1:0] shift_add;

  // pipeline handshake
  logic v1, v2, v3, v4, vo;
  logic rdy1, rdy2, rdy3, rdy4, rdyo;

  assign rdyo = !vo || result.ready;
  assign rdy4 = !v4 || rdyo;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign footer.ready = rdy1;
  assign in_accept    = footer.valid && footer.ready;
  assign last_accept  = in_accept && footer.window_last;

  // bytes past the 40th, after an error or after the fourth varint
  // only count
  assign decode_en = (byte_count < WINDOW_LEN) && !varint_error &&
                     (varint_index < VARINT_COUNT);
  assign acc_or    = accumulator | (WORD_W'(footer.data_byte[6:0]) << bit_shift);
  assign shift_add = bit_shift + DIGIT_BITS;

  always_comb begin
    byte_count_next   = byte_count;
    varint_index_next = varint_index;
    bit_shift_next    = bit_shift;
    accumulator_next  = accumulator;
    index_offset_next = index_offset;
    index_size_next   = index_size;
    varint_error_next = varint_error;
    if (decode_en) begin
      if (!footer.data_byte[7]) begin
        if (varint_index == VIDX_OFFSET) begin
          index_offset_next = acc_or;
        end else if (varint_index == VIDX_SIZE) begin
          index_size_next = acc_or;
        end
        varint_index_next = varint_index + 3'd1;
        accumulator_next  = '0;
        bit_shift_next    = '0;
      end else begin
        accumulator_next  = acc_or;
        bit_shift_next    = shift_add;
        varint_error_next = (shift_add >= SHIFT_LIMIT);
      end
    end
    if (byte_count < COUNT_MAX) begin
      byte_count_next = byte_count + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || last_accept) begin
      byte_count   <= '0;
      varint_index <= '0;
      bit_shift    <= '0;
      accumulator  <= '0;
      index_offset <= '0;
      index_size   <= '0;
      varint_error <= 1'b0;
    end else if (in_accept) begin
      byte_count   <= byte_count_next;
      varint_index <= varint_index_next;
      bit_shift    <= bit_shift_next;
      accumulator  <= accumulator_next;
      index_offset <= index_offset_next;
      index_size   <= index_size_next;
      varint_error <= varint_error_next;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: window record with offset, length and varint checks
  // ---------------------------------------------------------------
  status_t           st1;
  logic [OFFS_W-1:0] off1;
  logic [WORD_W-1:0] io1, is1;
  status_t           st1_next;

  always_comb begin
    priority if (footer.sig_offset < OFFS_W'(WINDOW_LEN)) begin
      st1_next = ST_OFFSET;
    end else if (byte_count_next != WINDOW_LEN) begin
      st1_next = ST_WINDOW;
    end else if (varint_error_next || varint_index_next < VARINT_COUNT) begin
      st1_next = ST_VARINT;
    end else begin
      st1_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= last_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && last_accept) begin
      st1  <= st1_next;
      off1 <= footer.sig_offset;
      io1  <= index_offset_next;
      is1  <= index_size_next;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: handle check, index end and signature base
  // ---------------------------------------------------------------
  status_t           st2;
  logic [OFFS_W-1:0] off2;
  logic [WORD_W-1:0] sum2, base2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      if (st1 == ST_OK && (is1 == '0 || io1 > OFFSET_LIMIT)) begin
        st2 <= ST_HANDLE;
      end else begin
        st2 <= st1;
      end
      off2  <= off1;
      sum2  <= io1 + is1;
      base2 <= WORD_W'(off1) - WINDOW_LEN_W;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: file start
  // ---------------------------------------------------------------
  status_t           st3;
  logic [OFFS_W-1:0] off3;
  logic [WORD_W-1:0] start3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      st3    <= st2;
      off3   <= off2;
      start3 <= base2 - sum2;
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: start range check, distances
  // ---------------------------------------------------------------
  status_t           st4;
  logic [WORD_W-1:0] bs4, size4;
  logic [WORD_W-1:0] off3_w;

  assign off3_w = WORD_W'(off3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      if (st3 == ST_OK && (start3[WORD_W-1] || start3 >= off3_w)) begin
        st4 <= ST_START;
      end else begin
        st4 <= st3;
      end
      bs4   <= off3_w - start3;
      size4 <= off3_w + SIG_LEN_W - start3;
    end
  end

  // ---------------------------------------------------------------
  // Output register: size limit, final status
  // ---------------------------------------------------------------
  status_t           st_out;
  logic [OFFS_W-1:0] bs_out, size_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (rdyo) begin
      vo <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdyo && v4) begin
      if (st4 == ST_OK && size4 > WORD_W'(max_size)) begin
        st_out   <= ST_SIZE;
        bs_out   <= '0;
        size_out <= '0;
      end else if (st4 == ST_OK) begin
        st_out   <= ST_OK;
        bs_out   <= bs4[OFFS_W-1:0];
        size_out <= size4[OFFS_W-1:0];
      end else begin
        st_out   <= st4;
        bs_out   <= '0;
        size_out <= '0;
      end
    end
  end

  assign result.valid     = vo;
  assign result.status    = st_out;
  assign result.backscan  = bs_out;
  assign result.file_size = size_out;

`ifndef SYNTH
  // an accepted file always ends 8 bytes past the signature start
  a_size_vs_backscan: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status == ST_OK |->
      result.file_size == result.backscan + 48'd8)
    else $error("file_size does not match backscan");

  // rejected windows report zero distances
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != ST_OK |->
      result.backscan == '0 && result.file_size == '0)
    else $error("nonzero distance on rejected window");

  // decode state clears after the window's last byte
  a_window_clear: assert property (@(posedge clk) disable iff (rst)
    last_accept |=> byte_count == '0 && varint_index == '0 && !varint_error)
    else $error("decode state not cleared after window end");

  // at most four varints are ever counted
  a_vidx_range: assert property (@(posedge clk) disable iff (rst)
    varint_index <= VARINT_COUNT)
    else $error("varint index overran");
`endif

endmodule

// ===== tb/table_footer_start_locator_tb.sv =====
`timescale 1ns / 1ps

module table_footer_start_locator_tb;
  import tfsl_pkg::*;

  // Quiet cycles on both channels, with work still pending, before we give up.
  localparam int WATCHDOG_LIMIT = 4000;
  // Long receiver hold-off: far longer than the check pipeline is deep.
  localparam int STALL_LEN = 300;
  // Margin after the last expected word before touching max_size or ending.
  // The result passes through the registered check pipeline, so this is generous.
  localparam int DRAIN_CYCLES = 12;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    status_t           status;
    logic [OFFS_W-1:0] backscan;
    logic [OFFS_W-1:0] file_size;
  } location_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_wr_en;
  logic [OFFS_W-1:0] cfg_wr_data;

  tfsl_in_if  footer_if();
  tfsl_out_if result_if();

  table_footer_start_locator i_dut (
    .clk         (clk),
    .rst         (rst),
    .footer      (footer_if),
    .result      (result_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the locator: decode state, max_size and the expected locations.
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] win_count;
  logic [VIDX_W-1:0]  win_varint;
  logic [SHIFT_W-1:0] win_shift;
  logic [WORD_W-1:0]  win_acc;
  logic [WORD_W-1:0]  win_index_off;
  logic [WORD_W-1:0]  win_index_size;
  logic               win_overlong;
  logic [OFFS_W-1:0]  size_limit;

  location_t expected_locations[$];

  int footer_words;
  int mismatches;
  int src_idle_pct;
  int snk_idle_pct;
  int stall_req_id;

  // Bytes of the footer window under construction, in wire order.
  logic [BYTE_W-1:0] window_bytes[$];

  task automatic clear_window_state();
    win_count      = '0;
    win_varint     = '0;
    win_shift      = '0;
    win_acc        = '0;
    win_index_off  = '0;
    win_index_size = '0;
    win_overlong   = 1'b0;
  endtask

  // Advance the shadow by one accepted footer word; on the window's final
  // byte, run the check chain and queue the location the block must report.
  task automatic locate_footer_byte(input logic [BYTE_W-1:0] b, input logic is_last,
                                    input logic [OFFS_W-1:0] sig_off);
    location_t         loc;
    logic [WORD_W-1:0] off_w;
    logic [WORD_W-1:0] start;
    logic [WORD_W-1:0] fsize;
    logic [WORD_W-1:0] span;
    // Bytes past the 40th are only counted, never decoded.
    if (win_count < WINDOW_LEN) begin
      // Decoding freezes after the fourth varint or once a varint overran.
      if (!win_overlong && win_varint < VARINT_COUNT && win_shift < SHIFT_LIMIT) begin
        // Digits above bit 63 fall off the top of the shift.
        win_acc = win_acc | ({57'd0, b[6:0]} << win_shift);
        if (!b[7]) begin
          if (win_varint == VIDX_OFFSET) win_index_off = win_acc;
          else if (win_varint == VIDX_SIZE) win_index_size = win_acc;
          win_varint = win_varint + 1'b1;
          win_acc    = '0;
          win_shift  = '0;
        end else begin
          win_shift = win_shift + DIGIT_BITS;
          // Continuation still set on the tenth byte.
          if (win_shift >= SHIFT_LIMIT) win_overlong = 1'b1;
        end
      end
    end
    if (win_count < COUNT_MAX) win_count = win_count + 1'b1;
    if (is_last) begin
      loc        = '0;
      loc.status = ST_OK;
      off_w      = {16'd0, sig_off};
      // First failing check wins.
      if (off_w < WINDOW_LEN_W) begin
        loc.status = ST_OFFSET;
      end else if (win_count != WINDOW_LEN) begin
        loc.status = ST_WINDOW;
      end else if (win_overlong || win_varint < VARINT_COUNT) begin
        loc.status = ST_VARINT;
      end else if (win_index_size == '0 || win_index_off > OFFSET_LIMIT) begin
        loc.status = ST_HANDLE;
      end else begin
        // 64-bit wraparound is intended; the start is read as signed.
        start = off_w - WINDOW_LEN_W - (win_index_off + win_index_size);
        if (start[63] || start >= off_w) begin
          loc.status = ST_START;
        end else begin
          fsize = off_w + SIG_LEN_W - start;
          if (fsize > {16'd0, size_limit}) begin
            loc.status = ST_SIZE;
          end else begin
            span          = off_w - start;
            loc.backscan  = span[OFFS_W-1:0];
            loc.file_size = fsize[OFFS_W-1:0];
          end
        end
      end
      expected_locations.insert(expected_locations.size(), loc);
      clear_window_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Footer side: one word per call, with random idle cycles ahead of it.
  // Drives on the falling edge, sees the handshake on the rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_footer_byte(input logic [BYTE_W-1:0] b, input logic is_last,
                                  input logic [OFFS_W-1:0] sig_off);
    while ($urandom_range(99) < src_idle_pct) begin
      footer_if.valid <= 1'b0;
      @(negedge clk);
    end
    footer_if.valid       <= 1'b1;
    footer_if.data_byte   <= b;
    footer_if.window_last <= is_last;
    footer_if.sig_offset  <= sig_off;
    @(posedge clk);
    while (!footer_if.ready) @(posedge clk);
    locate_footer_byte(b, is_last, sig_off);
    footer_words++;
    @(negedge clk);
  endtask

  function automatic logic [WORD_W-1:0] rand_bits(input int w);
    logic [WORD_W-1:0] r;
    r = {$urandom, $urandom};
    if (w < 64) r = r & ((64'd1 << w) - 64'd1);
    return r;
  endfunction

  // Little-endian base-128 encoding, padded with zero digits up to min_len.
  // A tenth byte only carries bit 63, so its upper digit bits get junk.
  task automatic add_varint(input logic [WORD_W-1:0] value, input int min_len);
    logic [WORD_W-1:0] rest;
    logic [6:0]        digit;
    logic              done;
    int                n;
    rest = value;
    done = 1'b0;
    n    = 0;
    while (!done) begin
      digit = rest[6:0];
      rest  = rest >> 7;
      if (n == 9) digit[6:1] = 6'($urandom);
      done = (n == 9) || (rest == '0 && n + 1 >= min_len);
      window_bytes.insert(window_bytes.size(), {!done, digit});
      n++;
    end
  endtask

  // Ten bytes, all with the continuation bit set: overlong varint.
  task automatic add_overlong_varint();
    repeat (10) window_bytes.insert(window_bytes.size(), {1'b1, 7'($urandom)});
  endtask

  // Sends len words; missing bytes are random, sig_offset is noise except
  // on the final word.
  task automatic send_window(input logic [OFFS_W-1:0] sig_off, input int len);
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      b = (i < window_bytes.size()) ? window_bytes[i] : 8'($urandom);
      send_footer_byte(b, i == len - 1, (i == len - 1) ? sig_off : OFFS_W'(rand_bits(48)));
    end
  endtask

  task automatic send_handle_window(input logic [WORD_W-1:0] index_off,
                                    input logic [WORD_W-1:0] index_size,
                                    input logic [OFFS_W-1:0] sig_off);
    window_bytes.delete();
    add_varint(rand_bits($urandom_range(0, 14)), 1);
    add_varint(rand_bits($urandom_range(0, 14)), 1);
    add_varint(index_off, 1);
    add_varint(index_size, 1);
    send_window(sig_off, 40);
  endtask

  // Mostly well-formed windows with random handles, steered at the check
  // boundaries; the rest are short, long, overlong, low-offset or pure noise.
  task automatic send_random_footer();
    int                pick;
    int                len;
    logic [WORD_W-1:0] index_off;
    logic [WORD_W-1:0] index_size;
    logic [WORD_W-1:0] budget;
    logic [OFFS_W-1:0] sig_off;
    pick       = $urandom_range(99);
    index_off  = rand_bits($urandom_range(0, 40));
    index_size = 64'd1 + rand_bits($urandom_range(0, 40));
    budget     = {16'd0, size_limit} - 64'd48;
    case ($urandom_range(9))
      0: index_off = OFFSET_LIMIT + rand_bits($urandom_range(0, 2));
      1: index_off = rand_bits(64);
      2: index_size = '0;
      // huge size wraps the start past the signature
      3: index_size = -rand_bits($urandom_range(3, 8));
      // file size right at max_size or one above
      4: if (size_limit > 48'd48 && budget > index_off)
           index_size = budget - index_off + rand_bits(1);
      default: ;
    endcase
    sig_off = OFFS_W'(64'd40 + index_off + index_size + rand_bits($urandom_range(0, 47)));
    case ($urandom_range(9))
      0: sig_off = OFFS_W'(rand_bits(48));
      1: sig_off = OFFS_W'(64'd39 + index_off + index_size);  // start at -1
      default: ;
    endcase
    window_bytes.delete();
    if (pick < 6) add_overlong_varint();
    else add_varint(rand_bits($urandom_range(0, 64)), $urandom_range(1, 3));
    add_varint(rand_bits($urandom_range(0, 64)), $urandom_range(1, 3));
    add_varint(index_off, $urandom_range(1, 3));
    add_varint(index_size, $urandom_range(1, 3));
    len = 40;
    if (pick >= 94) len = $urandom_range(1, 39);
    else if (pick >= 88) len = $urandom_range(41, 70);
    else if (pick >= 84) sig_off = OFFS_W'($urandom_range(0, 39));
    else if (pick >= 80) window_bytes.delete();
    send_window(sig_off, len);
  endtask

  // Wait until every expected word is out and the pipeline has settled.
  task automatic drain_results();
    footer_if.valid <= 1'b0;
    while (expected_locations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_max_size(input logic [OFFS_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    size_limit = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every status, the field extremes and the decode corner cases, run under
  // the reset max_size of 2^31.
  task automatic test_directed_footers();
    send_handle_window(64'd100, 64'd50, 48'd1000);
    // all-ones varint, zero padded to ten bytes, offset right at 2^40
    window_bytes.delete();
    add_varint('1, 1);
    add_varint('0, 10);
    add_varint(OFFSET_LIMIT, 1);
    add_varint(64'd1, 1);
    send_window('1, 40);
    send_handle_window(OFFSET_LIMIT + 64'd1, 64'd1, 48'd100000);
    send_handle_window(64'd3, 64'd0, 48'd100000);
    // signature offset below the window
    send_handle_window(64'd3, 64'd4, 48'd0);
    send_handle_window(64'd3, 64'd4, 48'd39);
    // window at offset 40: start lands below zero
    send_handle_window(64'd0, 64'd1, 48'd40);
    // start at -1, then at exactly 0
    send_handle_window(64'd100, 64'd50, 48'd189);
    send_handle_window(64'd100, 64'd50, 48'd190);
    // wrapped start at or past the signature
    send_handle_window(64'd0, -64'd50, 48'd5000);
    // file size at max_size, then one byte over
    send_handle_window(64'd0, 64'd2147483600, 48'h1_0000_0000);
    send_handle_window(64'd0, 64'd2147483601, 48'h1_0000_0000);
    send_handle_window(64'd5, 64'd7, '1);
    // short, long and saturating windows
    window_bytes.delete();
    send_window(48'd1000, 1);
    send_window(48'd1000, 39);
    send_handle_window(64'd100, 64'd50, 48'd1000);
    send_window(48'd1000, 41);
    send_window(48'd1000, 70);
    // overlong varint
    window_bytes.delete();
    add_overlong_varint();
    send_window(48'd1000, 40);
    // all continuation bytes with zero digits
    window_bytes.delete();
    repeat (40) window_bytes.insert(window_bytes.size(), 8'h80);
    send_window(48'd1000, 40);
  endtask

  task automatic test_size_limits();
    write_max_size('0);
    send_handle_window(64'd0, 64'd1, 48'd1000);
    // smallest possible file is 49 bytes
    write_max_size(48'd49);
    send_handle_window(64'd0, 64'd1, 48'd1000);
    send_handle_window(64'd0, 64'd2, 48'd1000);
    write_max_size('1);
    send_handle_window(OFFSET_LIMIT, 64'h8000_0000_0000, '1);
    send_handle_window(64'd1, 64'hFFFF_FFFF_FF00, '1);
  endtask

  task automatic test_random_footers(input int n_words, input int src_pct, input int snk_pct,
                                     input logic [OFFS_W-1:0] limit);
    int first;
    write_max_size(limit);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    first        = footer_words;
    while (footer_words - first < n_words) send_random_footer();
    drain_results();
  endtask

  // Receiver holds off while a burst of one-byte windows floods the check
  // pipeline; footer.ready must drop and recover.
  task automatic test_output_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    stall_req_id++;
    window_bytes.delete();
    repeat (40) send_window(OFFS_W'(rand_bits(48)), 1);
    send_handle_window(64'd100, 64'd50, 48'd1000);
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready, plus a long hold-off when one is requested.
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    int stall_seen;
    stall_left      = 0;
    stall_seen      = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req_id != stall_seen) begin
        stall_seen = stall_req_id;
        stall_left = STALL_LEN;
      end
      if (stall_left != 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Compare each accepted result word with the oldest expected location.
  always @(posedge clk) begin
    location_t loc;
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_locations.size() == 0) begin
        if (mismatches < SHOWN_MISMATCHES)
          $display("unexpected result word: status %0d backscan %0h file_size %0h",
                   result_if.status, result_if.backscan, result_if.file_size);
        mismatches++;
      end else begin
        loc = expected_locations.pop_front();
        if (result_if.status !== loc.status || result_if.backscan !== loc.backscan ||
            result_if.file_size !== loc.file_size) begin
          if (mismatches < SHOWN_MISMATCHES)
            $display("mismatch: status %0d/%0d backscan %0h/%0h file_size %0h/%0h (exp/got)",
                     loc.status, result_if.status, loc.backscan, result_if.backscan,
                     loc.file_size, result_if.file_size);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: only quiet cycles with work outstanding count.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((footer_if.valid && footer_if.ready) || (result_if.valid && result_if.ready))
        quiet = 0;
      else if (footer_if.valid || expected_locations.size() != 0)
        quiet++;
    end
    $display("table_footer_start_locator test failed");
    $finish;
  end

  initial begin
    rst                   = 1'b1;
    cfg_wr_en             = 1'b0;
    cfg_wr_data           = '0;
    footer_if.valid       = 1'b0;
    footer_if.data_byte   = '0;
    footer_if.window_last = 1'b0;
    footer_if.sig_offset  = '0;
    footer_words          = 0;
    mismatches            = 0;
    stall_req_id          = 0;
    src_idle_pct          = 26;
    snk_idle_pct          = 49;
    size_limit            = MAX_SIZE_RST;
    clear_window_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_footers();
    test_size_limits();
    test_random_footers(220, 26, 49, {16'($urandom), 32'($urandom)});
    test_random_footers(220, 49, 26, '1);
    test_random_footers(150, 0, 0, MAX_SIZE_RST);
    test_output_backpressure();

    drain_results();
    if (mismatches == 0) begin
      $display("table_footer_start_locator test passed");
    end else begin
      $display("table_footer_start_locator test failed");
    end
    $finish;
  end

endmodule
